// ===== src/gps_pkg.sv =====
// Shared types, codes and configuration-frame ROM for the gamepad poll sequencer.
// No dependencies; used by the interfaces, the register file, the core and the top level.
package gps_pkg;

  localparam int ANALOG_EXTRA_BYTES  = 16;
  localparam int DIGITAL_EXTRA_BYTES = 4;

  localparam int POS_W = 5;
  localparam int IDX_W = 4;  // configuration register index width

  // operation codes of an input word
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_POLL = 2'd1;
  localparam logic [1:0] OP_XFER = 2'd2;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_RUMBLE   = 4'd0;
  localparam logic [IDX_W-1:0] REG_PRESSURE = 4'd1;
  localparam logic [IDX_W-1:0] REG_DELAY    = 4'd2;
  localparam logic [IDX_W-1:0] REG_STALE    = 4'd3;

  // frame selects
  localparam logic [2:0] SEL_ENTER    = 3'd0;
  localparam logic [2:0] SEL_MODE     = 3'd1;
  localparam logic [2:0] SEL_RUMBLE   = 3'd2;
  localparam logic [2:0] SEL_PRESSURE = 3'd3;
  localparam logic [2:0] SEL_EXIT     = 3'd4;
  localparam logic [2:0] SEL_POLL     = 3'd5;

  // link status codes
  localparam logic [1:0] LINK_NONE    = 2'd0;
  localparam logic [1:0] LINK_DIGITAL = 2'd1;
  localparam logic [1:0] LINK_ANALOG  = 2'd2;

  localparam logic [7:0]  ID_DIGITAL  = 8'h73;
  localparam logic [7:0]  ID_ANALOG   = 8'h79;
  localparam logic [7:0]  FRAME_START = 8'h01;
  localparam logic [7:0]  POLL_CMD    = 8'h42;
  localparam logic [11:0] ELAPSED_MAX = 12'd4095;

  typedef struct packed {
    logic        rumble_enable;
    logic        pressure_enable;
    logic [7:0]  read_delay_ms;
    logic [11:0] stale_limit_ms;
  } gps_cfg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       motor_small;
    logic [7:0] motor_large;
    logic [7:0] rx_byte;
  } gps_item_t;

  typedef struct packed {
    logic        send_byte;
    logic [7:0]  tx_byte;
    logic        attention;
    logic [15:0] buttons;
    logic [15:0] previous_buttons;
    logic [1:0]  link_status;
    logic        analog_valid;
    logic [3:0]  analog_index;
    logic [7:0]  analog_value;
    logic        poll_done;
    logic        busy_res;
  } gps_result_t;

  // byte at a position of a configuration frame
  function automatic logic [7:0] cfg_rom_byte(logic [2:0] sel, logic [POS_W-1:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos == 5'd0) begin
      b = FRAME_START;
    end else begin
      case (sel)
        SEL_ENTER: begin
          if (pos == 5'd1) b = 8'h43;
          else if (pos == 5'd3) b = 8'h01;
        end
        SEL_MODE: begin
          if (pos == 5'd1) b = 8'h44;
          else if (pos == 5'd3) b = 8'h01;
          else if (pos == 5'd4) b = 8'h03;
        end
        SEL_RUMBLE: begin
          if (pos == 5'd1) b = 8'h4D;
          else if (pos == 5'd4) b = 8'h01;
        end
        SEL_PRESSURE: begin
          if (pos == 5'd1) b = 8'h4F;
          else if (pos == 5'd3 || pos == 5'd4) b = 8'hFF;
          else if (pos == 5'd5) b = 8'h03;
        end
        SEL_EXIT: begin
          if (pos == 5'd1) b = 8'h43;
          else if (pos >= 5'd4 && pos <= 5'd8) b = 8'h5A;
        end
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  function automatic logic [POS_W-1:0] cfg_frame_len(logic [2:0] sel);
    logic [POS_W-1:0] n;
    case (sel)
      SEL_ENTER, SEL_RUMBLE: n = 5'd5;
      SEL_MODE, SEL_PRESSURE, SEL_EXIT: n = 5'd9;
      default: n = 5'd5;
    endcase
    return n;
  endfunction

endpackage

// ===== src/gps_if.sv =====
// Valid/ready channel interfaces: input words, result words, register writes.
// Depends on gps_pkg for the index width.
interface gps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       motor_small;
  logic [7:0] motor_large;
  logic [7:0] rx_byte;
  modport source(output valid, operation, motor_small, motor_large, rx_byte, input ready);
  modport sink(input valid, operation, motor_small, motor_large, rx_byte, output ready);
endinterface

interface gps_out_if;
  logic        valid;
  logic        ready;
  logic        send_byte;
  logic [7:0]  tx_byte;
  logic        attention;
  logic [15:0] buttons;
  logic [15:0] previous_buttons;
  logic [1:0]  link_status;
  logic        analog_valid;
  logic [3:0]  analog_index;
  logic [7:0]  analog_value;
  logic        poll_done;
  logic        busy_res;
  modport source(output valid, send_byte, tx_byte, attention, buttons, previous_buttons,
                 link_status, analog_valid, analog_index, analog_value, poll_done,
                 busy_res, input ready);
  modport sink(input valid, send_byte, tx_byte, attention, buttons, previous_buttons,
               link_status, analog_valid, analog_index, analog_value, poll_done,
               busy_res, output ready);
endinterface

interface gps_cfg_if;
  import gps_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [11:0]      data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/gps_cfg_regs.sv =====
// Configuration register file of the poll sequencer.
// Depends on gps_pkg and gps_cfg_if.
module gps_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  gps_cfg_if.sink           cfg_chan,
  output gps_pkg::gps_cfg_t cfg
);
  import gps_pkg::*;

  gps_cfg_t cfg_r;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rumble_enable   <= 1'b0;
      cfg_r.pressure_enable <= 1'b0;
      cfg_r.read_delay_ms   <= 8'd5;
      cfg_r.stale_limit_ms  <= 12'd1500;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_RUMBLE:   cfg_r.rumble_enable   <= cfg_chan.data[0];
        REG_PRESSURE: cfg_r.pressure_enable <= cfg_chan.data[0];
        REG_DELAY:    cfg_r.read_delay_ms   <= cfg_chan.data[7:0];
        REG_STALE:    cfg_r.stale_limit_ms  <= cfg_chan.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/gps_core.sv =====
// Poll sequencer state machine: one word per step, result computed combinationally.
// Depends on gps_pkg.
module gps_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  gps_pkg::gps_item_t   item,
  input  gps_pkg::gps_cfg_t    cfg,
  output gps_pkg::gps_result_t result
);
  import gps_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FRAME, PH_GAP, PH_PREWAIT, PH_POLL, PH_EXTRA
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [2:0]       frame_select_r, frame_select_nxt;
  logic [POS_W-1:0] byte_position_r, byte_position_nxt;
  logic [7:0]       wait_count_r, wait_count_nxt;
  logic [11:0]      elapsed_ms_r, elapsed_ms_nxt;
  logic [8:0]       motor_latch_r, motor_latch_nxt;
  logic [7:0]       id_byte_r, id_byte_nxt;
  logic [15:0]      button_r, button_nxt;
  logic [15:0]      prev_button_r, prev_button_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             start;
  logic [2:0]       start_sel;
  logic             send;
  logic [7:0]       tx;
  logic             a_valid;
  logic [3:0]       a_index;
  logic [7:0]       a_value;
  logic             done;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       wc_dec;
  logic [7:0]       inv;
  logic [2:0]       cfg_next_sel;
  logic [POS_W-1:0] extra_need;

  // frame that follows a finished configuration frame
  function automatic logic [2:0] next_config(logic [2:0] sel, logic rumble, logic pressure);
    logic [2:0] n;
    if (sel == SEL_ENTER) n = SEL_MODE;
    else if (sel == SEL_MODE && rumble) n = SEL_RUMBLE;
    else if ((sel == SEL_MODE || sel == SEL_RUMBLE) && pressure) n = SEL_PRESSURE;
    else if (sel <= SEL_PRESSURE) n = SEL_EXIT;
    else n = SEL_POLL;
    return n;
  endfunction

  function automatic logic [7:0] poll_byte(logic [POS_W-1:0] pos, logic [8:0] motors);
    logic [7:0] b;
    case (pos)
      5'd0:    b = FRAME_START;
      5'd1:    b = POLL_CMD;
      5'd3:    b = {7'd0, motors[8]};
      5'd4:    b = motors[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  assign cfg_next_sel = next_config(frame_select_r, cfg.rumble_enable, cfg.pressure_enable);
  assign pos_inc      = byte_position_r + 5'd1;
  assign wc_dec       = (wait_count_r != 8'd0) ? wait_count_r - 8'd1 : 8'd0;
  assign inv          = ~item.rx_byte;
  assign extra_need   = (status_r == LINK_DIGITAL) ? POS_W'(DIGITAL_EXTRA_BYTES)
                                                   : POS_W'(ANALOG_EXTRA_BYTES);

  always_comb begin
    phase_nxt         = phase_r;
    frame_select_nxt  = frame_select_r;
    byte_position_nxt = byte_position_r;
    wait_count_nxt    = wait_count_r;
    elapsed_ms_nxt    = elapsed_ms_r;
    motor_latch_nxt   = motor_latch_r;
    id_byte_nxt       = id_byte_r;
    button_nxt        = button_r;
    prev_button_nxt   = prev_button_r;
    status_nxt        = status_r;
    start     = 1'b0;
    start_sel = frame_select_r;
    send      = 1'b0;
    tx        = 8'h00;
    a_valid   = 1'b0;
    a_index   = 4'd0;
    a_value   = 8'h00;
    done      = 1'b0;

    if (step) begin
      case (item.operation)
        OP_TICK: begin
          if (elapsed_ms_r != ELAPSED_MAX) elapsed_ms_nxt = elapsed_ms_r + 12'd1;
          if (phase_r == PH_GAP || phase_r == PH_PREWAIT) begin
            wait_count_nxt = wc_dec;
            if (wc_dec == 8'd0) begin
              start     = 1'b1;
              start_sel = (phase_r == PH_GAP) ? frame_select_r : SEL_POLL;
            end
          end
        end
        OP_POLL: begin
          if (phase_r == PH_IDLE) begin
            motor_latch_nxt = {item.motor_small, item.motor_large};
            if (elapsed_ms_r > cfg.stale_limit_ms) begin
              start     = 1'b1;
              start_sel = SEL_ENTER;
            end else if (elapsed_ms_r < {4'd0, cfg.read_delay_ms}) begin
              wait_count_nxt = cfg.read_delay_ms - elapsed_ms_r[7:0];
              phase_nxt      = PH_PREWAIT;
            end else begin
              start     = 1'b1;
              start_sel = SEL_POLL;
            end
          end
        end
        OP_XFER: begin
          if (phase_r == PH_FRAME) begin
            if (pos_inc >= cfg_frame_len(frame_select_r)) begin
              if (cfg.read_delay_ms == 8'd0) begin
                start     = 1'b1;
                start_sel = cfg_next_sel;
              end else begin
                frame_select_nxt  = cfg_next_sel;
                byte_position_nxt = pos_inc;
                wait_count_nxt    = cfg.read_delay_ms;
                phase_nxt         = PH_GAP;
              end
            end else begin
              byte_position_nxt = pos_inc;
              send = 1'b1;
              tx   = cfg_rom_byte(frame_select_r, pos_inc);
            end
          end else if (phase_r == PH_POLL) begin
            if (byte_position_r == 5'd1) id_byte_nxt = item.rx_byte;
            else if (byte_position_r == 5'd3) button_nxt = {button_r[15:8], inv};
            else if (byte_position_r == 5'd4) button_nxt = {inv, button_r[7:0]};
            byte_position_nxt = pos_inc;
            if (pos_inc < 5'd5) begin
              send = 1'b1;
              tx   = poll_byte(pos_inc, motor_latch_r);
            end else if (id_byte_r == ID_DIGITAL || id_byte_r == ID_ANALOG) begin
              status_nxt        = (id_byte_r == ID_DIGITAL) ? LINK_DIGITAL : LINK_ANALOG;
              phase_nxt         = PH_EXTRA;
              byte_position_nxt = '0;
              send = 1'b1;
            end else begin
              status_nxt     = LINK_NONE;
              phase_nxt      = PH_IDLE;
              elapsed_ms_nxt = '0;
              done = 1'b1;
            end
          end else if (phase_r == PH_EXTRA) begin
            a_valid = 1'b1;
            a_index = byte_position_r[3:0];
            a_value = item.rx_byte;
            byte_position_nxt = pos_inc;
            if (pos_inc >= extra_need) begin
              phase_nxt      = PH_IDLE;
              elapsed_ms_nxt = '0;
              done = 1'b1;
            end else begin
              send = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    if (start) begin
      frame_select_nxt  = start_sel;
      byte_position_nxt = '0;
      send = 1'b1;
      tx   = FRAME_START;
      if (start_sel == SEL_POLL) begin
        phase_nxt       = PH_POLL;
        prev_button_nxt = button_r;
      end else begin
        phase_nxt = PH_FRAME;
      end
    end

    result.send_byte        = send;
    result.tx_byte          = tx;
    result.attention        = (phase_nxt == PH_FRAME || phase_nxt == PH_POLL ||
                               phase_nxt == PH_EXTRA);
    result.buttons          = button_nxt;
    result.previous_buttons = prev_button_nxt;
    result.link_status      = status_nxt;
    result.analog_valid     = a_valid;
    result.analog_index     = a_index;
    result.analog_value     = a_value;
    result.poll_done        = done;
    result.busy_res         = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      frame_select_r  <= '0;
      byte_position_r <= '0;
      wait_count_r    <= '0;
      elapsed_ms_r    <= '0;
      motor_latch_r   <= '0;
      id_byte_r       <= '0;
      button_r        <= '0;
      prev_button_r   <= '0;
      status_r        <= LINK_NONE;
    end else begin
      phase_r         <= phase_nxt;
      frame_select_r  <= frame_select_nxt;
      byte_position_r <= byte_position_nxt;
      wait_count_r    <= wait_count_nxt;
      elapsed_ms_r    <= elapsed_ms_nxt;
      motor_latch_r   <= motor_latch_nxt;
      id_byte_r       <= id_byte_nxt;
      button_r        <= button_nxt;
      prev_button_r   <= prev_button_nxt;
      status_r        <= status_nxt;
    end
  end

endmodule

// ===== src/gamepad_poll_sequencer.sv =====
// Top level of the gamepad poll sequencer: input register, core, result register.
// Depends on gps_pkg, gps_if, gps_cfg_regs and gps_core.

// Takes one input word per clock: a millisecond tick, a poll request with motor
// levels, or a finished byte exchange with the received byte, and returns exactly
// one result word for each. A word passes through an input register, the core's
// combinational state update and a result register; throughput is one word per
// cycle while the result side keeps taking words.
// Register writes are taken at any time but must only be made while the
// sequencer is idle.
module gamepad_poll_sequencer (
  input  logic      clk,
  input  logic      rst_n,
  gps_in_if.sink    in_chan,
  gps_out_if.source out_chan,
  gps_cfg_if.sink   cfg_chan
);
  import gps_pkg::*;

  gps_cfg_t    cfg;
  gps_item_t   in_item_r;
  logic        in_valid_r;
  gps_result_t result;
  gps_result_t out_res_r;
  logic        out_valid_r;
  logic        out_free;
  logic        step;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign step          = in_valid_r && out_free;
  assign in_chan.ready = !in_valid_r || out_free;

  gps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  gps_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_valid_r <= 1'b1;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_item_r.operation   <= in_chan.operation;
      in_item_r.motor_small <= in_chan.motor_small;
      in_item_r.motor_large <= in_chan.motor_large;
      in_item_r.rx_byte     <= in_chan.rx_byte;
    end
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.send_byte        = out_res_r.send_byte;
  assign out_chan.tx_byte          = out_res_r.tx_byte;
  assign out_chan.attention        = out_res_r.attention;
  assign out_chan.buttons          = out_res_r.buttons;
  assign out_chan.previous_buttons = out_res_r.previous_buttons;
  assign out_chan.link_status      = out_res_r.link_status;
  assign out_chan.analog_valid     = out_res_r.analog_valid;
  assign out_chan.analog_index     = out_res_r.analog_index;
  assign out_chan.analog_value     = out_res_r.analog_value;
  assign out_chan.poll_done        = out_res_r.poll_done;
  assign out_chan.busy_res         = out_res_r.busy_res;

  // a finished poll leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.poll_done |-> !out_res_r.busy_res)
    else $error("poll_done with busy_res set");

  // extra bytes are only read on a live link
  a_extra_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.analog_valid |-> out_res_r.link_status != LINK_NONE)
    else $error("analog byte while disconnected");

  // a byte is only sent inside an open frame
  a_send_attn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.send_byte |-> out_res_r.attention)
    else $error("send_byte without attention");

  // a held input word is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_free |=> in_valid_r)
    else $error("input word lost under stall");

endmodule
